/* rtl/core/plsy_pkg.sv */
// Shared constants and types for the point list sorter.
// No dependencies; used by point_list_sort_by_y and its checker.
package plsy_pkg;

  localparam int unsigned MaxPoints = 32;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

endpackage

/* rtl/core/point_list_sort_by_y.sv */
// Point list sorter top level: point store, bubble sort sequencer, output register.
// Depends on plsy_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid_i / in_ready_o | point_x_i, point_y_i, last_point_i
//  out     | out_valid_o/ out_ready_i| sorted_x_o, sorted_y_o, final_out_o, overflow_o
//
// Loading accepts one point per cycle. A list of n points is then sorted in place in one
// single-port-write, one-read synchronous memory by bubble-sort passes, each pass
// shortening the range by one entry. Each sorted point is read back, loaded into the
// output register and held there until taken. No input is taken from the last
// point of a list until its final result is taken. Reset needs no clearing pass.

module point_list_sort_by_y (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [plsy_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [plsy_pkg::CoordW-1:0]  point_y_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [plsy_pkg::CoordW-1:0]  sorted_x_o,
  output logic signed [plsy_pkg::CoordW-1:0]  sorted_y_o,
  output logic                                final_out_o,
  output logic                                overflow_o
);

  typedef enum logic [7:0] {
    S_LOAD      = 8'b0000_0001,
    S_PSTART    = 8'b0000_0010,
    S_PFIRST    = 8'b0000_0100,
    S_PRUN      = 8'b0000_1000,
    S_PEND      = 8'b0001_0000,
    S_EMIT_RD   = 8'b0010_0000,
    S_EMIT_LD   = 8'b0100_0000,
    S_EMIT_HOLD = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [plsy_pkg::CntW-1:0]  fill_q, fill_d;
  logic                       drop_q, drop_d;
  logic [plsy_pkg::AddrW-1:0] lim_q, lim_d;
  logic [plsy_pkg::AddrW-1:0] idx_q, idx_d;
  plsy_pkg::point_t           carry_q, carry_d;

  plsy_pkg::point_t           mem_q [plsy_pkg::MaxPoints];
  plsy_pkg::point_t           rdata_q;
  logic                       mem_we;
  logic [plsy_pkg::AddrW-1:0] mem_waddr, mem_raddr;
  plsy_pkg::point_t           mem_wdata, in_point;

  plsy_pkg::point_t           out_q;
  logic                       out_load, final_d, final_q, ovf_q;

  logic in_accept, out_accept, full, carry_gt, emit_last;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_EMIT_HOLD);
  assign out_accept  = out_valid_o && out_ready_i;

  assign in_point.x = point_x_i;
  assign in_point.y = point_y_i;
  assign full       = (fill_q == plsy_pkg::CntW'(plsy_pkg::MaxPoints));
  // Strictly greater keeps equal keys in arrival order.
  assign carry_gt   = (carry_q.y > rdata_q.y);
  assign emit_last  = ((plsy_pkg::CntW'(idx_q) + plsy_pkg::CntW'(1)) == fill_q);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    drop_d    = drop_q;
    lim_d     = lim_q;
    idx_d     = idx_q;
    carry_d   = carry_q;
    mem_we    = 1'b0;
    mem_waddr = fill_q[plsy_pkg::AddrW-1:0];
    mem_wdata = in_point;
    mem_raddr = idx_q;
    out_load  = 1'b0;
    final_d   = emit_last;
    case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          if (!full) begin
            mem_we = 1'b1;
            fill_d = fill_q + plsy_pkg::CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_point_i) begin
            idx_d = '0;
            lim_d = plsy_pkg::AddrW'(fill_d - plsy_pkg::CntW'(1));
            state_d = (fill_d == plsy_pkg::CntW'(1)) ? S_EMIT_RD : S_PSTART;
          end
        end
      end
      S_PSTART: begin
        mem_raddr = '0;
        state_d   = S_PFIRST;
      end
      S_PFIRST: begin
        carry_d   = rdata_q;
        mem_raddr = plsy_pkg::AddrW'(1);
        idx_d     = plsy_pkg::AddrW'(1);
        state_d   = S_PRUN;
      end
      S_PRUN: begin
        // The smaller of carry and the entry just read settles one place lower.
        mem_we    = 1'b1;
        mem_waddr = idx_q - plsy_pkg::AddrW'(1);
        if (carry_gt) begin
          mem_wdata = rdata_q;
        end else begin
          mem_wdata = carry_q;
          carry_d   = rdata_q;
        end
        mem_raddr = idx_q + plsy_pkg::AddrW'(1);
        if (idx_q == lim_q) begin
          state_d = S_PEND;
        end else begin
          idx_d = idx_q + plsy_pkg::AddrW'(1);
        end
      end
      S_PEND: begin
        mem_we    = 1'b1;
        mem_waddr = lim_q;
        mem_wdata = carry_q;
        lim_d     = lim_q - plsy_pkg::AddrW'(1);
        idx_d     = '0;
        state_d   = (lim_q == plsy_pkg::AddrW'(1)) ? S_EMIT_RD : S_PSTART;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_load = 1'b1;
        state_d  = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (out_accept) begin
          if (final_q) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + plsy_pkg::AddrW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      lim_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      lim_q   <= lim_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (out_load) begin
      out_q   <= rdata_q;
      final_q <= final_d;
      ovf_q   <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign sorted_x_o  = out_q.x;
  assign sorted_y_o  = out_q.y;
  assign final_out_o = final_q;
  assign overflow_o  = ovf_q;

endmodule

/* rtl/core/plsy_checker.sv */
// Port-level checker for point_list_sort_by_y, attached by bind.
// Depends on plsy_pkg for coordinate widths.
module plsy_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               last_point_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [plsy_pkg::CoordW-1:0] sorted_x_o,
  input logic signed [plsy_pkg::CoordW-1:0] sorted_y_o,
  input logic                               final_out_o,
  input logic                               overflow_o
);

  // The block never loads and emits at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // The request that ends a list closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_point_i) |=> !in_ready_o)
    else $error("input still ready after the last point");

  // Taking the final result reopens the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_out_o) |=> in_ready_o)
    else $error("input not reopened after the final result");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sorted_x_o) && $stable(sorted_y_o) &&
       $stable(final_out_o) && $stable(overflow_o)))
    else $error("stalled result changed");

endmodule

bind point_list_sort_by_y plsy_checker u_plsy_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_point_i (last_point_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sorted_x_o   (sorted_x_o),
  .sorted_y_o   (sorted_y_o),
  .final_out_o  (final_out_o),
  .overflow_o   (overflow_o)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for point_list_sort_by_y: directed and random point lists go in,
// and a stable sort by y in the bench predicts every emitted point. Depends on plsy_pkg.
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandPoints = 190;
  localparam int unsigned CalmDepth  = 30;

  typedef logic signed [plsy_pkg::CoordW-1:0] coord_t;

  typedef struct packed {
    plsy_pkg::point_t pt;
    logic             last;
  } point_req_t;

  typedef struct packed {
    plsy_pkg::point_t pt;
    logic             final_pt;
    logic             ovf;
  } sorted_pt_t;

  logic   clk        = 1'b0;
  logic   rst_n      = 1'b0;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  coord_t point_x    = '0;
  coord_t point_y    = '0;
  logic   last_point = 1'b0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  coord_t sorted_x;
  coord_t sorted_y;
  logic   final_out;
  logic   overflow;

  point_req_t       point_queue[$];
  point_req_t       cur_req;
  plsy_pkg::point_t held_pts[$];
  logic             pts_dropped = 1'b0;
  sorted_pt_t       sorted_due[$];

  logic        calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned cycles = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned points_sent = 0;
  int unsigned lists_done = 0;
  int unsigned ovf_lists = 0;
  int unsigned pts_checked = 0;

  point_list_sort_by_y i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .last_point_i (last_point),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sorted_x_o   (sorted_x),
    .sorted_y_o   (sorted_y),
    .final_out_o  (final_out),
    .overflow_o   (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  task automatic add_point(input coord_t x, input coord_t y, input logic last);
    point_req_t req;
    req.pt.x = x;
    req.pt.y = y;
    req.last = last;
    point_queue = {point_queue, req};
  endtask

  // Narrow keys force many equal y values so that sort stability is exercised.
  function automatic coord_t pick_coord(input logic narrow);
    int     sel;
    int     v;
    coord_t c;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      v = $urandom_range(0, 3);
      case (v)
        0: c = 16'sh8000;
        1: c = 16'sh7fff;
        2: c = '0;
        default: c = '1;
      endcase
    end else if (narrow) begin
      v = $urandom_range(0, 6);
      c = coord_t'(v - 3);
    end else begin
      c = coord_t'($urandom);
    end
    return c;
  endfunction

  // Accepted request: store the point and, on the last point, sort stably by y
  // and queue every point of the list in its sorted position.
  function automatic void take_point(input point_req_t req);
    plsy_pkg::point_t tmp;
    sorted_pt_t       res;
    int               n;
    if (held_pts.size() < plsy_pkg::MaxPoints) begin
      held_pts = {held_pts, req.pt};
    end else begin
      pts_dropped = 1'b1;
    end
    if (req.last) begin
      n = held_pts.size();
      for (int pass = 0; pass + 1 < n; pass++) begin
        for (int j = 0; j + 1 < n - pass; j++) begin
          if ($signed(held_pts[j].y) > $signed(held_pts[j+1].y)) begin
            tmp           = held_pts[j];
            held_pts[j]   = held_pts[j+1];
            held_pts[j+1] = tmp;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        res.pt       = held_pts[k];
        res.final_pt = (k == n - 1);
        res.ovf      = pts_dropped;
        sorted_due   = {sorted_due, res};
      end
      lists_done++;
      if (pts_dropped) begin
        ovf_lists++;
      end
      held_pts.delete();
      pts_dropped = 1'b0;
    end
  endfunction

  function automatic void check_sorted_pt();
    sorted_pt_t want;
    if (sorted_due.size() == 0) begin
      if (mismatch_cnt < 10) begin
        $display("ERROR: unexpected point x=%0d y=%0d final=%0b ovf=%0b",
                 sorted_x, sorted_y, final_out, overflow);
      end
      mismatch_cnt++;
    end else begin
      want = sorted_due[0];
      sorted_due.delete(0);
      pts_checked++;
      if (sorted_x !== want.pt.x || sorted_y !== want.pt.y ||
          final_out !== want.final_pt || overflow !== want.ovf) begin
        if (mismatch_cnt < 10) begin
          $display("ERROR: point mismatch exp x=%0d y=%0d final=%0b ovf=%0b",
                   $signed(want.pt.x), $signed(want.pt.y), want.final_pt, want.ovf);
          $display("                      got x=%0d y=%0d final=%0b ovf=%0b",
                   sorted_x, sorted_y, final_out, overflow);
        end
        mismatch_cnt++;
      end
    end
  endfunction

  // Request driver: holds each point until accepted, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          take_point(cur_req);
          points_sent++;
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          cur_req = point_queue[0];
          point_queue.delete(0);
          point_x    <= cur_req.pt.x;
          point_y    <= cur_req.pt.y;
          last_point <= cur_req.last;
          in_valid   <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= (point_queue.size() < CalmDepth);
    end
  end

  // Result monitor: checks every accepted point and stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_sorted_pt();
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) begin
          out_gap = $urandom_range(1, 12);
        end
      end
    end
  end

  initial begin
    int   rand_pts;
    int   list_idx;
    int   len;
    int   sel;
    logic narrow;

    // Single point list at the coordinate extremes.
    add_point(16'sh7fff, 16'sh8000, 1'b1);
    // Extremes of both fields; two points share the top key and must keep order.
    add_point(16'sh8000, 16'sh7fff, 1'b0);
    add_point(16'sh0000, 16'sh0000, 1'b0);
    add_point(-16'sd1,   -16'sd1,   1'b0);
    add_point(16'sd1,    16'sh8000, 1'b0);
    add_point(16'sh7fff, 16'sh7fff, 1'b1);
    // All keys equal: output order is arrival order.
    for (int i = 1; i <= 4; i++) begin
      add_point(coord_t'(i), 16'sd5, i == 4);
    end
    // Strictly descending keys.
    for (int i = 0; i < 6; i++) begin
      add_point(coord_t'(-i), coord_t'(500 - 100 * i), i == 5);
    end

    // Random lists, mostly short; a full list, a list whose last point is dropped,
    // and a list that overflows by several points are mixed in.
    rand_pts = 0;
    list_idx = 0;
    while (rand_pts < RandPoints) begin
      if (list_idx == 1) begin
        len = plsy_pkg::MaxPoints;
      end else if (list_idx == 6) begin
        len = plsy_pkg::MaxPoints + 1;
      end else if (list_idx == 11) begin
        len = plsy_pkg::MaxPoints + 3;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          len = $urandom_range(1, 6);
        end else if (sel < 17) begin
          len = $urandom_range(7, 16);
        end else if (sel < 19) begin
          len = $urandom_range(17, plsy_pkg::MaxPoints);
        end else begin
          len = $urandom_range(plsy_pkg::MaxPoints + 1, plsy_pkg::MaxPoints + 4);
        end
      end
      narrow = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        add_point(pick_coord(1'b0), pick_coord(narrow), i == len - 1);
      end
      rand_pts += len;
      list_idx++;
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (point_queue.size() != 0 || in_valid || sorted_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d points in %0d lists, %0d of them overflowing the store.",
             points_sent, lists_done, ovf_lists);
    $display("Checked %0d sorted points, %0d mismatches.", pts_checked, mismatch_cnt);
    if (mismatch_cnt == 0 && sorted_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles.", cycles);
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/plsy_pkg.sv
rtl/core/point_list_sort_by_y.sv
rtl/core/plsy_checker.sv
tb/sv/tb.sv
